[rtl/core/rpr_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package rpr_pkg;

    // field widths fixed by the item formats
    localparam int LEVEL_W    = 16;
    localparam int OUT_TIME_W = 20;
    localparam int RISE_W     = 15;
    localparam int STEP_W     = 8;

    // default time counter width
    localparam int TIME_BITS_DEF = 20;

    // configuration defaults
    localparam logic [RISE_W-1:0] MIN_RISE_RESET  = 15'd128;
    localparam logic [STEP_W-1:0] TIME_STEP_RESET = 8'd10;

    // register index, taken from paddr[2]
    localparam logic REG_MIN_RISE  = 1'b0;
    localparam logic REG_TIME_STEP = 1'b1;

    // command codes
    localparam logic CMD_START  = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    typedef struct packed {
        logic                       command;
        logic signed [LEVEL_W-1:0]  sample_value;
    } sample_t;

    typedef struct packed {
        logic                       recorded;
        logic signed [LEVEL_W-1:0]  first_level;
        logic signed [LEVEL_W-1:0]  mid_level;
        logic [OUT_TIME_W-1:0]      mid_time;
        logic signed [LEVEL_W-1:0]  last_level;
        logic [OUT_TIME_W-1:0]      last_time;
        logic [OUT_TIME_W-1:0]      elapsed_time;
    } result_t;

endpackage

`default_nettype wire

[rtl/core/rpr_in_reg.sv]
`timescale 1ns / 1ps
`default_nettype none

module rpr_in_reg
    import rpr_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    sample_valid,
    output logic         sample_ready,
    input  wire sample_t sample,
    input  wire logic    advance,
    output logic         item_valid,
    output sample_t      item
);

    logic    valid_reg;
    sample_t item_reg;

    // stage is free when empty or when its item moves on this cycle
    assign sample_ready = !valid_reg || advance;
    assign item_valid   = valid_reg;
    assign item         = item_reg;

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (sample_ready)
        begin
            valid_reg <= sample_valid;
        end
    end

    // payload capture on each transfer
    always_ff @(posedge clk)
    begin
        if (sample_valid && sample_ready)
        begin
            item_reg <= sample;
        end
    end

endmodule

`default_nettype wire

[rtl/core/rpr_tracker.sv]
`timescale 1ns / 1ps
`default_nettype none

module rpr_tracker
    import rpr_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEF
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              item_valid,
    input  wire sample_t           item,
    input  wire logic [RISE_W-1:0] min_rise,
    input  wire logic [STEP_W-1:0] time_step,
    output logic                   advance,
    output logic                   result_valid,
    input  wire logic              result_ready,
    output result_t                result
);

    localparam int LVL_EXT_W = LEVEL_W + 2;

    typedef logic signed [LEVEL_W-1:0] level_t;
    typedef logic [TIME_BITS-1:0]      stamp_t;

    // curve record
    level_t start_level_reg,      start_level_next;
    level_t middle_level_reg,     middle_level_next;
    stamp_t middle_stamp_reg,     middle_stamp_next;
    level_t latest_level_reg,     latest_level_next;
    stamp_t latest_stamp_reg,     latest_stamp_next;
    level_t checkpoint_level_reg, checkpoint_level_next;
    stamp_t checkpoint_stamp_reg, checkpoint_stamp_next;
    stamp_t plateau_start_reg,    plateau_start_next;
    stamp_t elapsed_reg,          elapsed_next;
    logic   recorded_next;

    logic    out_valid_reg;
    result_t result_reg;
    result_t result_next;

    logic [TIME_BITS:0]          time_sum;
    logic [TIME_BITS:0]          avg_sum;
    logic signed [LVL_EXT_W-1:0] rise_limit;
    logic                        risen;

    // result register is free when empty or taken this cycle
    assign advance      = item_valid && (!out_valid_reg || result_ready);
    assign result_valid = out_valid_reg;
    assign result       = result_reg;

    // rise test at full width, no wrap
    assign rise_limit = LVL_EXT_W'(latest_level_reg) + $signed({3'b000, min_rise});
    assign risen      = LVL_EXT_W'(item.sample_value) >= rise_limit;

    // saturating time advance
    assign time_sum = {1'b0, elapsed_reg} + (TIME_BITS + 1)'(time_step);
    assign avg_sum  = {1'b0, elapsed_next} + {1'b0, plateau_start_reg};

    // low output bits of a time value
    function automatic logic [OUT_TIME_W-1:0] time_out(input stamp_t t);
        logic [OUT_TIME_W+TIME_BITS-1:0] ext;
        ext = {{OUT_TIME_W{1'b0}}, t};
        return ext[OUT_TIME_W-1:0];
    endfunction

    // record update for one item
    always_comb
    begin
        start_level_next      = start_level_reg;
        middle_level_next     = middle_level_reg;
        middle_stamp_next     = middle_stamp_reg;
        latest_level_next     = latest_level_reg;
        latest_stamp_next     = latest_stamp_reg;
        checkpoint_level_next = checkpoint_level_reg;
        checkpoint_stamp_next = checkpoint_stamp_reg;
        plateau_start_next    = plateau_start_reg;
        recorded_next         = 1'b0;
        elapsed_next          = time_sum[TIME_BITS] ? '1 : time_sum[TIME_BITS-1:0];

        if (item.command == CMD_START)
        begin
            start_level_next      = '0;
            middle_level_next     = '0;
            middle_stamp_next     = '0;
            latest_level_next     = item.sample_value;
            latest_stamp_next     = '0;
            checkpoint_level_next = '0;
            checkpoint_stamp_next = '0;
            plateau_start_next    = '0;
            elapsed_next          = '0;
        end
        else if (start_level_reg == '0)
        begin
            // waiting for the first rise
            if (latest_level_reg != '0 && risen)
            begin
                start_level_next      = latest_level_reg;
                middle_level_next     = item.sample_value;
                middle_stamp_next     = elapsed_next;
                latest_level_next     = item.sample_value;
                latest_stamp_next     = elapsed_next;
                plateau_start_next    = elapsed_next;
                checkpoint_level_next = item.sample_value;
                checkpoint_stamp_next = elapsed_next;
                recorded_next         = 1'b1;
            end
        end
        else
        begin
            // shift points along when time doubles
            if ({1'b0, elapsed_next} >= {checkpoint_stamp_reg, 1'b0})
            begin
                middle_level_next     = checkpoint_level_reg;
                middle_stamp_next     = checkpoint_stamp_reg;
                checkpoint_level_next = latest_level_reg;
                checkpoint_stamp_next = latest_stamp_reg;
            end
            if (risen)
            begin
                if (latest_level_reg == middle_level_next)
                begin
                    middle_stamp_next = latest_stamp_reg;
                end
                if (latest_level_reg == checkpoint_level_next)
                begin
                    checkpoint_stamp_next = latest_stamp_reg;
                end
                latest_level_next  = item.sample_value;
                latest_stamp_next  = elapsed_next;
                plateau_start_next = elapsed_next;
                recorded_next      = 1'b1;
            end
            else
            begin
                // midpoint of the time spent at this level
                latest_stamp_next = avg_sum[TIME_BITS:1];
            end
        end
    end

    // result fields
    always_comb
    begin
        result_next.recorded     = recorded_next;
        result_next.first_level  = start_level_next;
        result_next.mid_level    = middle_level_next;
        result_next.mid_time     = time_out(middle_stamp_next);
        result_next.last_level   = latest_level_next;
        result_next.last_time    = time_out(latest_stamp_next);
        result_next.elapsed_time = time_out(elapsed_next);
    end

    // record state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_level_reg      <= '0;
            middle_level_reg     <= '0;
            middle_stamp_reg     <= '0;
            latest_level_reg     <= '0;
            latest_stamp_reg     <= '0;
            checkpoint_level_reg <= '0;
            checkpoint_stamp_reg <= '0;
            plateau_start_reg    <= '0;
            elapsed_reg          <= '0;
        end
        else if (advance)
        begin
            start_level_reg      <= start_level_next;
            middle_level_reg     <= middle_level_next;
            middle_stamp_reg     <= middle_stamp_next;
            latest_level_reg     <= latest_level_next;
            latest_stamp_reg     <= latest_stamp_next;
            checkpoint_level_reg <= checkpoint_level_next;
            checkpoint_stamp_reg <= checkpoint_stamp_next;
            plateau_start_reg    <= plateau_start_next;
            elapsed_reg          <= elapsed_next;
        end
    end

    // result valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || result_ready)
        begin
            out_valid_reg <= item_valid;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

endmodule

`default_nettype wire

[rtl/core/rise_point_recorder.sv]
`timescale 1ns / 1ps
`default_nettype none

// Rise point recorder: keeps first, mid and last points of a rising
// temperature curve for a later exponential fit.
// Sample channel (sample_valid / sample_ready / sample): a start command
// clears the record and seeds the last level; a sample command advances
// elapsed time by time_step and may start timing or record a new rise.
// Result channel (result_valid / result_ready / result): exactly one result
// per item, in order, showing the record after that item.
// An accepted item waits in the input register; its record update is then
// loaded into the result register, which drives result_valid and result.
// Throughput: one item per cycle while result_ready is high; the record
// update is combinational and feeds the next item directly.
// When the receiver stalls, the result register holds, the input register
// keeps one more item, and then sample_ready drops.
// Reset clears the record and both pipeline stages and loads min_rise = 128
// and time_step = 10. The APB port (pready always high) writes min_rise at
// address 0 and time_step at address 4; write only while the block is idle.

module rise_point_recorder
    import rpr_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        sample_valid,
    output logic             sample_ready,
    input  wire sample_t     sample,
    output logic             result_valid,
    input  wire logic        result_ready,
    output result_t          result,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic [RISE_W-1:0] min_rise_reg;
    logic [STEP_W-1:0] time_step_reg;
    logic              cfg_write;
    logic              advance;
    logic              item_valid;
    sample_t           item;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_rise_reg  <= MIN_RISE_RESET;
            time_step_reg <= TIME_STEP_RESET;
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                REG_MIN_RISE:  min_rise_reg  <= pwdata[RISE_W-1:0];
                REG_TIME_STEP: time_step_reg <= pwdata[STEP_W-1:0];
                default:       ;
            endcase
        end
    end

    // register readback
    always_comb
    begin
        unique case (paddr[2])
            REG_MIN_RISE:  prdata = {{(32-RISE_W){1'b0}}, min_rise_reg};
            REG_TIME_STEP: prdata = {{(32-STEP_W){1'b0}}, time_step_reg};
            default:       prdata = '0;
        endcase
    end

    rpr_in_reg u_in_reg (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample),
        .advance      (advance),
        .item_valid   (item_valid),
        .item         (item)
    );

    rpr_tracker #(
        .TIME_BITS (TIME_BITS)
    ) u_tracker (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item         (item),
        .min_rise     (min_rise_reg),
        .time_step    (time_step_reg),
        .advance      (advance),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

`default_nettype wire
